@@ rtl/core/mss_pkg.sv @@
// shared types, constants and lookup tables for the morse symbol sequencer
package mss_pkg;

    localparam int SYM_W      = 6;
    localparam int DUR_W      = 18;
    localparam int UNIT_W     = 16;
    localparam int CNT_W      = 3;
    localparam int DASH_W     = 5;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;
    localparam int SYM_COUNT  = 37;

    localparam logic [SYM_W-1:0]  SYM_SPACE        = SYM_W'(36);
    localparam logic [UNIT_W-1:0] UNIT_TICKS_RESET = UNIT_W'(100);

    // register byte addresses
    localparam logic [APB_AW-1:0] ADDR_UNIT_TICKS = APB_AW'(0);

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             lamp;
    } t_in_item;

    typedef struct packed {
        logic             lamp_select;
        logic             lamp_on;
        logic [DUR_W-1:0] duration;
        logic             last_segment;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ON,
        ST_OFF,
        ST_SPACE,
        ST_GAP
    } t_state;

    typedef enum logic [1:0] {
        SEG_MARK,
        SEG_ELEM_GAP,
        SEG_SPACE,
        SEG_CHAR_GAP
    } t_seg_kind;

    typedef struct packed {
        logic      load;
        logic      emit;
        logic      advance;
        t_seg_kind kind;
    } t_dp_cmd;

    typedef struct packed {
        logic sym_known;
        logic sym_space;
        logic last_elem;
        logic out_free;
    } t_dp_status;

    localparam logic [CNT_W-1:0] ELEM_COUNT [SYM_COUNT] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
        3'd0
    };

    // bit i set: element i is a dash, element 0 sent first
    localparam logic [DASH_W-1:0] ELEM_DASH [SYM_COUNT] = '{
        5'h02, 5'h01, 5'h05, 5'h01, 5'h00, 5'h04, 5'h03, 5'h00, 5'h00, 5'h0E, 5'h05,
        5'h02, 5'h03, 5'h01, 5'h07, 5'h06, 5'h0B, 5'h02, 5'h00, 5'h01, 5'h04, 5'h08,
        5'h06, 5'h09, 5'h0D, 5'h03,
        5'h1F, 5'h1E, 5'h1C, 5'h18, 5'h10, 5'h00, 5'h01, 5'h03, 5'h07, 5'h0F,
        5'h00
    };

    function automatic logic [CNT_W-1:0] f_elem_count(input logic [SYM_W-1:0] sym);
        logic [CNT_W-1:0] res;
        res = '0;
        if (sym < SYM_W'(SYM_COUNT)) begin
            res = ELEM_COUNT[sym];
        end
        return res;
    endfunction

    function automatic logic [DASH_W-1:0] f_elem_dash(input logic [SYM_W-1:0] sym);
        logic [DASH_W-1:0] res;
        res = '0;
        if (sym < SYM_W'(SYM_COUNT)) begin
            res = ELEM_DASH[sym];
        end
        return res;
    endfunction

endpackage

@@ rtl/core/morse_symbol_sequencer.sv @@
// top level of the morse symbol sequencer: register port, controller and datapath
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_stall    i_in_item  (symbol, lamp)
//  out       output     o_out_valid / i_out_stall  o_out_item (lamp_select, lamp_on,
//                                                               duration, last_segment)
//  config    input      apb write/read             unit_ticks at address 0
//
//  an item is loaded, then one segment goes out per cycle unless the output stalls:
//  a mark and a gap per element and a character gap for a letter or digit, a space
//  and a character gap for a word space; the single segment register sets this pace
//  an unknown symbol is dropped in its load cycle
//  reset clears the state machine and output valid; unit_ticks returns to 100
//  a stall on the output holds the segment and pauses the sequence
module morse_symbol_sequencer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  mss_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output mss_pkg::t_out_item         o_out_item,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mss_pkg::APB_AW-1:0] paddr,
    input  logic [mss_pkg::APB_DW-1:0] pwdata,
    output logic [mss_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import mss_pkg::*;

    logic [UNIT_W-1:0] r_unit_ticks;
    t_dp_cmd           dp_cmd;
    t_dp_status        dp_status;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks <= UNIT_TICKS_RESET;
        end else if (psel && penable && pwrite && (paddr == ADDR_UNIT_TICKS)) begin
            r_unit_ticks <= pwdata[UNIT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_UNIT_TICKS) begin
            prdata = APB_DW'(r_unit_ticks);
        end
    end

    mss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall)
    );

    mss_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_item    (i_in_item),
        .i_unit_ticks (r_unit_ticks),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item)
    );

endmodule

@@ rtl/core/mss_ctrl.sv @@
// controller state machine that steps through the segments of one symbol
module mss_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  mss_pkg::t_dp_status i_status,
    output mss_pkg::t_dp_cmd   o_cmd,
    output logic               o_in_stall
);
    import mss_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.load    = 1'b0;
        o_cmd.emit    = 1'b0;
        o_cmd.advance = 1'b0;
        o_cmd.kind    = SEG_MARK;
        o_in_stall    = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.sym_space) begin
                        n_state = ST_SPACE;
                    end else if (i_status.sym_known) begin
                        n_state = ST_ON;
                    end
                end
            end
            ST_ON: begin
                o_cmd.kind = SEG_MARK;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_OFF;
                end
            end
            ST_OFF: begin
                o_cmd.kind = SEG_ELEM_GAP;
                if (i_status.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.advance = 1'b1;
                    n_state       = i_status.last_elem ? ST_GAP : ST_ON;
                end
            end
            ST_SPACE: begin
                o_cmd.kind = SEG_SPACE;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_GAP;
                end
            end
            ST_GAP: begin
                o_cmd.kind = SEG_CHAR_GAP;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/mss_dp.sv @@
// datapath: symbol pattern registers, element counter, duration and output register
module mss_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mss_pkg::t_in_item             i_in_item,
    input  logic [mss_pkg::UNIT_W-1:0]    i_unit_ticks,
    input  mss_pkg::t_dp_cmd              i_cmd,
    output mss_pkg::t_dp_status           o_status,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mss_pkg::t_out_item            o_out_item
);
    import mss_pkg::*;

    logic              r_lamp;
    logic [CNT_W-1:0]  r_count;
    logic [DASH_W-1:0] r_dash;
    logic [CNT_W-1:0]  r_idx;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic [DUR_W-1:0]  unit_ext;
    logic [DUR_W-1:0]  n_duration;
    logic              n_on;
    logic              n_last;
    logic              is_dash;

    assign o_status.sym_known = (i_in_item.symbol < SYM_W'(SYM_COUNT));
    assign o_status.sym_space = (i_in_item.symbol == SYM_SPACE);
    assign o_status.last_elem = (r_idx == r_count - CNT_W'(1));
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign unit_ext = DUR_W'(i_unit_ticks);
    assign is_dash  = r_dash[r_idx];

    always_comb begin
        n_on       = 1'b0;
        n_last     = 1'b0;
        n_duration = unit_ext;
        case (i_cmd.kind)
            SEG_MARK: begin
                n_on       = 1'b1;
                n_duration = is_dash ? (unit_ext << 1) + unit_ext : unit_ext;
            end
            SEG_ELEM_GAP: begin
                n_duration = unit_ext;
            end
            SEG_SPACE: begin
                n_duration = unit_ext << 2;
            end
            SEG_CHAR_GAP: begin
                n_last     = 1'b1;
                n_duration = (unit_ext << 1) + unit_ext;
            end
            default: begin
                n_duration = unit_ext;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_item.lamp_select  <= r_lamp;
            r_out_item.lamp_on      <= n_on;
            r_out_item.duration     <= n_duration;
            r_out_item.last_segment <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lamp  <= i_in_item.lamp;
            r_count <= f_elem_count(i_in_item.symbol);
            r_dash  <= f_elem_dash(i_in_item.symbol);
            r_idx   <= '0;
        end else if (i_cmd.advance) begin
            r_idx <= r_idx + CNT_W'(1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
